// ===== sv/framed_register_access_responder_macros.svh =====
// Assertion macros used by the checker file.
`ifndef FRAMED_REGISTER_ACCESS_RESPONDER_MACROS_SVH
`define FRAMED_REGISTER_ACCESS_RESPONDER_MACROS_SVH

// Check a property outside reset.
`define FRA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define FRA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/fra_pkg.sv =====
// Shared types and constants of the framed register access responder.
`default_nettype none
package fra_pkg;

    localparam int REG_BYTES_DEF = 32;
    localparam int ARG_BYTES_DEF = 34;
    localparam int MAX_READ_DEF  = 32;

    localparam logic [7:0]  START_BYTE      = 8'hAA;
    localparam logic [15:0] TIMEOUT_RST     = 16'd150;
    localparam logic [7:0]  READ_CODE_RST   = 8'd0;
    localparam logic [7:0]  WRITE_CODE_RST  = 8'd1;
    localparam logic [7:0]  RETURN_CODE_RST = 8'd2;
    localparam logic [15:0] TICKS_MAX       = 16'hFFFF;
    localparam logic [8:0]  ARGC_MAX        = 9'd511;

    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_READ    = 2'd1;
    localparam logic [1:0] CFG_WRITE   = 2'd2;
    localparam logic [1:0] CFG_RETURN  = 2'd3;

    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_CHKSUM  = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    typedef enum logic [3:0] {
        P_IDLE, P_INSTR, P_ARGS, P_SUMLO, P_SUMHI,
        R_STAT, RD_H0, RD_H1, RD_H2, RD_BODY, RD_SLO, RD_SHI,
        WR_ADDR, WR_DATA, PL_ADDR, PL_EMIT
    } state_t;

    typedef enum logic [2:0] {
        SRC_ZERO, SRC_START, SRC_RETCODE, SRC_COUNT, SRC_REG, SRC_SUMLO, SRC_SUMHI, SRC_RAM
    } src_t;

    typedef struct packed {
        logic       start;
        logic       instr_ld;
        logic       arg_ld;
        logic       slo_ld;
        logic       tick;
        logic       init_read;
        logic       init_write;
        logic       init_pay;
        logic       step;
        logic       sum_acc;
        logic       ram_rd;
        logic       ram_two;
        logic       reg_wr;
        logic       out_load;
        src_t       out_src;
        logic [1:0] out_kind;
        logic [1:0] out_status;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        logic is_start;
        logic tmo_tick;
        logic tmo_byte;
        logic args_done;
        logic sum_match;
        logic is_read;
        logic is_write;
        logic is_ret;
        logic loop_done;
        logic loop_final;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ===== sv/fra_ram.sv =====
// Generic single-port-write RAM with registered read.
`default_nettype none
module fra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 34,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/fra_dp.sv =====
// Datapath: configuration, frame registers, stores, reply loop and output register.
`default_nettype none
module fra_dp #(
    parameter int REG_BYTES = 32,
    parameter int ARG_BYTES = 34,
    parameter int MAX_READ  = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    input  wire logic [7:0]   in_byte,
    input  wire fra_pkg::cmd_t cmd,
    output fra_pkg::sts_t     sts,
    input  wire logic         out_ready,
    output logic              out_valid,
    output logic [1:0]        out_kind,
    output logic [7:0]        out_data,
    output logic [1:0]        out_status,
    output logic              out_last
);
    import fra_pkg::*;

    localparam int AAW = (ARG_BYTES > 1) ? $clog2(ARG_BYTES) : 1;
    localparam int RW  = (REG_BYTES > 1) ? $clog2(REG_BYTES) : 1;
    localparam logic [8:0] ARG_LIM   = 9'(ARG_BYTES);
    localparam logic [8:0] REG_LIM   = 9'(REG_BYTES);
    localparam logic [8:0] WR_CAP    = 9'(ARG_BYTES - 2);
    localparam logic [8:0] PAY_CAP_A = 9'(ARG_BYTES - 1);
    localparam logic [8:0] PAY_CAP_M = 9'(MAX_READ + 5);
    localparam logic [7:0] RD_CAP    = 8'(MAX_READ);

    logic [15:0] timeout_reg;
    logic [7:0]  read_code_reg, write_code_reg, return_code_reg;
    logic [15:0] sum_reg, rsum_reg, rsum_next;
    logic [7:0]  rsl_reg, instr_reg, arg0_reg, arg1_reg;
    logic [8:0]  argc_reg, argc_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [7:0]  idx_reg, len_reg, len_next, a0_next, a1_next;
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg, out_status_reg;
    logic [7:0]  out_data_reg, out_sel;
    logic        out_last_reg;
    logic [7:0]  regs_reg [REG_BYTES];
    logic [8:0]  ridx, raddr9, wr_rem, len_w, len_p;
    logic [7:0]  rval, ram_q;
    logic        is_read, is_write, is_ret, out_free;

    // Configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= TIMEOUT_RST;
            read_code_reg   <= READ_CODE_RST;
            write_code_reg  <= WRITE_CODE_RST;
            return_code_reg <= RETURN_CODE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_TIMEOUT: timeout_reg     <= cfg_data;
                CFG_READ:    read_code_reg   <= cfg_data[7:0];
                CFG_WRITE:   write_code_reg  <= cfg_data[7:0];
                CFG_RETURN:  return_code_reg <= cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    assign is_read  = (instr_reg == read_code_reg);
    assign is_write = !is_read && (instr_reg == write_code_reg);
    assign is_ret   = !is_read && !is_write && (instr_reg == return_code_reg);

    assign argc_next    = (argc_reg == ARGC_MAX) ? ARGC_MAX : argc_reg + 9'd1;
    assign a0_next      = (argc_reg == 9'd0) ? in_byte : arg0_reg;
    assign a1_next      = (argc_reg == 9'd1) ? in_byte : arg1_reg;
    assign elapsed_next = (elapsed_reg == TICKS_MAX) ? TICKS_MAX : elapsed_reg + 16'd1;

    // Frame registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            rsl_reg     <= '0;
            instr_reg   <= '0;
            argc_reg    <= '0;
            arg0_reg    <= '0;
            arg1_reg    <= '0;
            elapsed_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                sum_reg     <= {8'd0, START_BYTE};
                elapsed_reg <= '0;
            end
            if (cmd.tick)
            begin
                elapsed_reg <= elapsed_next;
            end
            if (cmd.instr_ld)
            begin
                instr_reg <= in_byte;
                sum_reg   <= sum_reg + {8'd0, in_byte};
                argc_reg  <= '0;
            end
            if (cmd.arg_ld)
            begin
                sum_reg  <= sum_reg + {8'd0, in_byte};
                argc_reg <= argc_next;
                arg0_reg <= a0_next;
                arg1_reg <= a1_next;
            end
            if (cmd.slo_ld)
            begin
                rsl_reg <= in_byte;
            end
        end
    end

    // Argument store.
    assign raddr9 = {1'b0, idx_reg} + (cmd.ram_two ? 9'd2 : 9'd1);

    fra_ram #(.WIDTH(8), .DEPTH(ARG_BYTES)) u_arg_ram (
        .clk   (clk),
        .we    (cmd.arg_ld && (argc_reg < ARG_LIM)),
        .waddr (argc_reg[AAW-1:0]),
        .wdata (in_byte),
        .re    (cmd.ram_rd),
        .raddr (raddr9[AAW-1:0]),
        .rdata (ram_q)
    );

    // Register store.
    assign ridx = {1'b0, arg0_reg} + {1'b0, idx_reg};
    assign rval = (ridx < REG_LIM) ? regs_reg[ridx[RW-1:0]] : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_BYTES; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else if (cmd.reg_wr)
        begin
            regs_reg[ridx[RW-1:0]] <= ram_q;
        end
    end

    // Reply loop.
    assign wr_rem = REG_LIM - {1'b0, arg0_reg};
    always_comb
    begin
        len_w = {1'b0, arg1_reg};
        if (len_w > wr_rem)
        begin
            len_w = wr_rem;
        end
        if (len_w > WR_CAP)
        begin
            len_w = WR_CAP;
        end
        if ({1'b0, arg0_reg} >= REG_LIM)
        begin
            len_w = '0;
        end
        len_p = {1'b0, arg0_reg};
        if (len_p > PAY_CAP_A)
        begin
            len_p = PAY_CAP_A;
        end
        if (len_p > PAY_CAP_M)
        begin
            len_p = PAY_CAP_M;
        end
        len_next = len_reg;
        if (cmd.init_read)
        begin
            len_next = (arg1_reg > RD_CAP) ? RD_CAP : arg1_reg;
        end
        else if (cmd.init_write)
        begin
            len_next = len_w[7:0];
        end
        else if (cmd.init_pay)
        begin
            len_next = len_p[7:0];
        end
        rsum_next = rsum_reg;
        if (cmd.init_read)
        begin
            rsum_next = {8'd0, START_BYTE} + {8'd0, return_code_reg} + {8'd0, len_next};
        end
        else if (cmd.sum_acc)
        begin
            rsum_next = rsum_reg + {8'd0, rval};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            len_reg  <= '0;
            rsum_reg <= '0;
        end
        else
        begin
            len_reg  <= len_next;
            rsum_reg <= rsum_next;
            if (cmd.init_read || cmd.init_write || cmd.init_pay)
            begin
                idx_reg <= '0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + 8'd1;
            end
        end
    end

    // Output register.
    always_comb
    begin
        case (cmd.out_src)
            SRC_START:   out_sel = START_BYTE;
            SRC_RETCODE: out_sel = return_code_reg;
            SRC_COUNT:   out_sel = len_reg;
            SRC_REG:     out_sel = rval;
            SRC_SUMLO:   out_sel = rsum_reg[7:0];
            SRC_SUMHI:   out_sel = rsum_reg[15:8];
            SRC_RAM:     out_sel = ram_q;
            default:     out_sel = 8'd0;
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_kind_reg   <= cmd.out_kind;
            out_data_reg   <= out_sel;
            out_status_reg <= cmd.out_status;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

    always_comb
    begin
        sts.is_start  = (in_byte == START_BYTE);
        sts.tmo_tick  = (elapsed_next > timeout_reg);
        sts.tmo_byte  = (elapsed_reg > timeout_reg);
        sts.sum_match = ({in_byte, rsl_reg} == sum_reg);
        sts.is_read   = is_read;
        sts.is_write  = is_write;
        sts.is_ret    = is_ret;
        if (is_read)
        begin
            sts.args_done = (argc_next >= 9'd2);
        end
        else if (is_write)
        begin
            sts.args_done = (argc_next >= 9'd2) && ({1'b0, argc_next} >= {2'b0, a1_next} + 10'd2);
        end
        else if (is_ret)
        begin
            sts.args_done = (argc_next >= 9'd1) && ({1'b0, argc_next} >= {2'b0, a0_next} + 10'd1);
        end
        else
        begin
            sts.args_done = 1'b0;
        end
        sts.loop_done  = (idx_reg == len_reg);
        sts.loop_final = ({1'b0, idx_reg} + 9'd1 == {1'b0, len_reg});
        sts.out_free   = out_free;
    end
endmodule
`default_nettype wire

// ===== sv/fra_ctrl.sv =====
// Controller: frame phases and reply sequencing.
`default_nettype none
module fra_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_opcode,
    output logic               in_ready,
    input  wire fra_pkg::sts_t sts,
    output fra_pkg::cmd_t      cmd
);
    import fra_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] stat_reg, stat_next;
    logic       acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            stat_reg  <= ST_NONE;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
        end
    end

    assign in_ready = (state_reg inside {P_IDLE, P_INSTR, P_ARGS, P_SUMLO, P_SUMHI});
    assign acc      = in_ready && in_valid;

    always_comb
    begin
        state_next = state_reg;
        stat_next  = stat_reg;
        cmd        = '0;
        cmd.out_src = SRC_ZERO;
        if (acc && in_opcode)
        begin
            // tick
            if (state_reg != P_IDLE)
            begin
                cmd.tick = 1'b1;
                if (sts.tmo_tick)
                begin
                    stat_next  = ST_TIMEOUT;
                    state_next = R_STAT;
                end
            end
        end
        else if (acc)
        begin
            case (state_reg)
                P_IDLE:
                begin
                    if (sts.is_start)
                    begin
                        cmd.start  = 1'b1;
                        state_next = P_INSTR;
                    end
                end
                P_INSTR:
                begin
                    cmd.instr_ld = 1'b1;
                    state_next   = P_ARGS;
                end
                P_ARGS:
                begin
                    cmd.arg_ld = 1'b1;
                    if (sts.args_done)
                    begin
                        state_next = P_SUMLO;
                    end
                end
                P_SUMLO:
                begin
                    cmd.slo_ld = 1'b1;
                    state_next = P_SUMHI;
                end
                default:
                begin
                    if (!sts.sum_match)
                    begin
                        stat_next  = ST_CHKSUM;
                        state_next = R_STAT;
                    end
                    else if (sts.is_read)
                    begin
                        cmd.init_read = 1'b1;
                        state_next    = RD_H0;
                    end
                    else if (sts.is_write)
                    begin
                        cmd.init_write = 1'b1;
                        state_next     = WR_ADDR;
                    end
                    else if (sts.is_ret)
                    begin
                        cmd.init_pay = 1'b1;
                        state_next   = PL_ADDR;
                    end
                    else
                    begin
                        stat_next  = ST_OK;
                        state_next = R_STAT;
                    end
                end
            endcase
            // drop an open frame that ran out of time
            if ((state_reg inside {P_INSTR, P_ARGS, P_SUMLO}) && sts.tmo_byte)
            begin
                stat_next  = ST_TIMEOUT;
                state_next = R_STAT;
            end
        end
        else
        begin
            case (state_reg)
                R_STAT:
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_kind   = KIND_STATUS;
                        cmd.out_status = stat_reg;
                        cmd.out_last   = 1'b1;
                        state_next     = P_IDLE;
                    end
                end
                RD_H0, RD_H1, RD_H2, RD_SLO:
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_TX;
                        case (state_reg)
                            RD_H0:
                            begin
                                cmd.out_src = SRC_START;
                                state_next  = RD_H1;
                            end
                            RD_H1:
                            begin
                                cmd.out_src = SRC_RETCODE;
                                state_next  = RD_H2;
                            end
                            RD_H2:
                            begin
                                cmd.out_src = SRC_COUNT;
                                state_next  = RD_BODY;
                            end
                            default:
                            begin
                                cmd.out_src = SRC_SUMLO;
                                state_next  = RD_SHI;
                            end
                        endcase
                    end
                end
                RD_BODY:
                begin
                    if (sts.loop_done)
                    begin
                        state_next = RD_SLO;
                    end
                    else if (sts.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_TX;
                        cmd.out_src  = SRC_REG;
                        cmd.step     = 1'b1;
                        cmd.sum_acc  = 1'b1;
                    end
                end
                RD_SHI:
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_kind   = KIND_TX;
                        cmd.out_src    = SRC_SUMHI;
                        cmd.out_status = ST_OK;
                        cmd.out_last   = 1'b1;
                        state_next     = P_IDLE;
                    end
                end
                WR_ADDR:
                begin
                    if (sts.loop_done)
                    begin
                        stat_next  = ST_OK;
                        state_next = R_STAT;
                    end
                    else
                    begin
                        cmd.ram_rd  = 1'b1;
                        cmd.ram_two = 1'b1;
                        state_next  = WR_DATA;
                    end
                end
                WR_DATA:
                begin
                    cmd.reg_wr = 1'b1;
                    cmd.step   = 1'b1;
                    state_next = WR_ADDR;
                end
                PL_ADDR:
                begin
                    if (sts.loop_done)
                    begin
                        stat_next  = ST_OK;
                        state_next = R_STAT;
                    end
                    else
                    begin
                        cmd.ram_rd = 1'b1;
                        state_next = PL_EMIT;
                    end
                end
                PL_EMIT:
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_kind   = KIND_PAYLOAD;
                        cmd.out_src    = SRC_RAM;
                        cmd.out_status = sts.loop_final ? ST_OK : ST_NONE;
                        cmd.out_last   = sts.loop_final;
                        cmd.step       = 1'b1;
                        state_next     = sts.loop_final ? P_IDLE : PL_ADDR;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/framed_register_access_responder.sv =====
// Top level of the framed register access responder.
//
//  channel  dir  tdata                         tuser       tlast
//  s_axis   in   rx_byte[7:0]                  opcode      -
//  m_axis   out  data_byte[7:0], status[9:8]   kind[1:0]   last
//  cfg      in   cfg_index selects register, cfg_data holds value
//
// One request at a time; bytes and ticks are taken only while no reply is under way.
// A read reply holds up to MAX_READ+5 bytes; a write stores each byte in a RAM read
// state and a register write state, and a payload delivers each byte in a RAM read
// state and an emit state, as the argument RAM has a registered read.
// Reset clears the register store and frame state at once; no clearing pass.
// m_axis stalls hold the sequencer; the output register frees the input side.
`default_nettype none
module framed_register_access_responder #(
    parameter int REG_BYTES = fra_pkg::REG_BYTES_DEF,
    parameter int ARG_BYTES = fra_pkg::ARG_BYTES_DEF,
    parameter int MAX_READ  = fra_pkg::MAX_READ_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    input  wire logic        s_axis_tuser,   // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // data_byte[7:0], status[9:8], zero
    output logic [1:0]       m_axis_tuser,   // kind[1:0]
    output logic             m_axis_tlast,   // last
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import fra_pkg::*;

    cmd_t       cmd;
    sts_t       sts;
    logic [7:0] out_data;
    logic [1:0] out_status;

    fra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_opcode (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fra_dp #(
        .REG_BYTES (REG_BYTES),
        .ARG_BYTES (ARG_BYTES),
        .MAX_READ  (MAX_READ)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_byte    (s_axis_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_kind   (m_axis_tuser),
        .out_data   (out_data),
        .out_status (out_status),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, out_status, out_data};
endmodule
`default_nettype wire

// ===== sv/fra_checker.sv =====
// Port checker for the framed register access responder, with its bind.
`default_nettype none
`include "framed_register_access_responder_macros.svh"
module fra_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);
    import fra_pkg::*;

    `FRA_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !m_axis_tvalid, "result during reset")
    `FRA_ASSERT(a_stat_last, m_axis_tvalid && (m_axis_tuser == KIND_STATUS) |-> m_axis_tlast, "status result not last")
    `FRA_ASSERT(a_stat_zero, m_axis_tvalid && (m_axis_tuser == KIND_STATUS) |-> (m_axis_tdata[7:0] == 8'd0), "status result carries data")
    `FRA_ASSERT(a_last_status, m_axis_tvalid |-> ((m_axis_tdata[9:8] != ST_NONE) == m_axis_tlast), "status and last disagree")
    `FRA_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule

bind framed_register_access_responder fra_checker u_fra_checker (.*);
`default_nettype wire
